// ----- src/rv32_pkg.sv -----
// rv32_pkg: shared types, action codes and constants for the RV32I execute unit.
// No dependencies.
`timescale 1ns / 1ps
package rv32_pkg;
	localparam int DATA_BYTES_DEF = 4096;

	localparam logic [4:0] ACT_ADD   = 5'd0;
	localparam logic [4:0] ACT_SUB   = 5'd1;
	localparam logic [4:0] ACT_AND   = 5'd2;
	localparam logic [4:0] ACT_OR    = 5'd3;
	localparam logic [4:0] ACT_XOR   = 5'd4;
	localparam logic [4:0] ACT_SLT   = 5'd5;
	localparam logic [4:0] ACT_SLTU  = 5'd6;
	localparam logic [4:0] ACT_ADDI  = 5'd7;
	localparam logic [4:0] ACT_ANDI  = 5'd8;
	localparam logic [4:0] ACT_ORI   = 5'd9;
	localparam logic [4:0] ACT_SLLI  = 5'd10;
	localparam logic [4:0] ACT_SRLI  = 5'd11;
	localparam logic [4:0] ACT_SRAI  = 5'd12;
	localparam logic [4:0] ACT_LUI   = 5'd13;
	localparam logic [4:0] ACT_AUIPC = 5'd14;
	localparam logic [4:0] ACT_BEQ   = 5'd15;
	localparam logic [4:0] ACT_BNE   = 5'd16;
	localparam logic [4:0] ACT_BLT   = 5'd17;
	localparam logic [4:0] ACT_BGE   = 5'd18;
	localparam logic [4:0] ACT_BLTU  = 5'd19;
	localparam logic [4:0] ACT_BGEU  = 5'd20;
	localparam logic [4:0] ACT_JAL   = 5'd21;
	localparam logic [4:0] ACT_JALR  = 5'd22;
	localparam logic [4:0] ACT_LB    = 5'd23;
	localparam logic [4:0] ACT_LBU   = 5'd24;
	localparam logic [4:0] ACT_LW    = 5'd25;
	localparam logic [4:0] ACT_SB    = 5'd26;
	localparam logic [4:0] ACT_SW    = 5'd27;
	localparam logic [4:0] ACT_ECALL = 5'd28;

	localparam logic [4:0] REG_A0 = 5'd10;
	localparam logic [4:0] REG_A7 = 5'd17;

	localparam logic [31:0] SVC_CODE_INT  = 32'd1;
	localparam logic [31:0] SVC_CODE_STR  = 32'd4;
	localparam logic [31:0] SVC_CODE_EXIT = 32'd10;

	localparam logic [1:0] SVC_NONE = 2'd0;
	localparam logic [1:0] SVC_INT  = 2'd1;
	localparam logic [1:0] SVC_STR  = 2'd2;
	localparam logic [1:0] SVC_EXIT = 2'd3;

	typedef struct packed {
		logic [4:0]  action;
		logic [4:0]  dest_reg;
		logic [31:0] imm_value;
	} instr_t;

	typedef struct packed {
		logic        write_enable;
		logic [31:0] write_value;
		logic        jumped;
		logic [31:0] next_pc;
		logic [1:0]  service;
		logic [31:0] service_arg;
	} result_t;

	// register write-back bundle
	typedef struct packed {
		logic        en;
		logic [4:0]  addr;
		logic [31:0] data;
	} rf_wr_t;
endpackage

// ----- src/rv32_regfile.sv -----
// rv32_regfile: 32x32 register file, synchronous read with write-through.
// Depends on rv32_pkg. Four read ports (rs1, rs2, and the fixed a0 and a7 registers).
`timescale 1ns / 1ps
module rv32_regfile (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [4:0]           ra1,
	input  logic [4:0]           ra2,
	output logic [31:0]          rd1,
	output logic [31:0]          rd2,
	output logic [31:0]          a0_val,
	output logic [31:0]          a7_val,
	input  rv32_pkg::rf_wr_t     wr
);
	// Small file (32 entries), reset to zero, held in flops.
	logic [31:0] regs_q [32];

	function automatic logic [31:0] rdp(input logic [4:0] a, input logic [31:0] cur,
		input rv32_pkg::rf_wr_t w);
		logic [31:0] r;
		r = cur;
		if (w.en && w.addr == a) r = w.data;
		if (a == 5'd0) r = 32'd0;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) regs_q[i] <= 32'd0;
		end else if (wr.en && wr.addr != 5'd0) begin
			regs_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd1 <= rdp(ra1, regs_q[ra1], wr);
			rd2 <= rdp(ra2, regs_q[ra2], wr);
			a0_val <= rdp(rv32_pkg::REG_A0, regs_q[rv32_pkg::REG_A0], wr);
			a7_val <= rdp(rv32_pkg::REG_A7, regs_q[rv32_pkg::REG_A7], wr);
		end
	end
endmodule

// ----- src/rv32_dmem.sv -----
// rv32_dmem: byte-addressed data memory as four byte banks, one word row each,
// with synchronous (registered) read. Depends on rv32_pkg.
`timescale 1ns / 1ps
module rv32_dmem #(
	parameter int DATA_BYTES = rv32_pkg::DATA_BYTES_DEF
) (
	input  logic        clk,
	input  logic        re,
	input  logic [31:0] raddr,
	output logic [31:0] rdata,
	input  logic        we,
	input  logic [31:0] waddr,
	input  logic [3:0]  wbytes,
	input  logic [31:0] wdata
);
	// DATA_BYTES must be a power of two, which is not checked here; addresses wrap on their low bits.
	localparam int AW = $clog2(DATA_BYTES);
	localparam int BANK = DATA_BYTES / 4;
	localparam int BW = AW - 2;

	logic [7:0] bank0 [BANK];
	logic [7:0] bank1 [BANK];
	logic [7:0] bank2 [BANK];
	logic [7:0] bank3 [BANK];

	logic [AW-1:0] rbase, wbase;
	logic [1:0]    rl, wl;
	logic [BW-1:0] rrow, wrow, rrow1, wrow1;
	logic [BW-1:0] rb [4];
	logic [BW-1:0] wbr [4];
	logic [1:0]    wsel [4];
	logic [7:0]    wbd [4];
	logic          wbe [4];
	logic [1:0]    rsel0_q;
	logic [7:0]    q0, q1, q2, q3;
	logic [7:0]    qs [4];

	assign rbase = raddr[AW-1:0];
	assign wbase = waddr[AW-1:0];
	assign rl = rbase[1:0];
	assign wl = wbase[1:0];
	assign rrow = rbase[AW-1:2];
	assign wrow = wbase[AW-1:2];
	assign rrow1 = rrow + BW'(1);
	assign wrow1 = wrow + BW'(1);

	// Banks below the start lane hold the bytes that spill into the next row.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rb[k] = (2'(k) < rl) ? rrow1 : rrow;
			wbr[k] = (2'(k) < wl) ? wrow1 : wrow;
			wsel[k] = 2'(2'(k) - wl);
			wbd[k] = wdata[8*wsel[k] +: 8];
			wbe[k] = we && wbytes[wsel[k]];
		end
	end

	always_ff @(posedge clk) begin
		if (wbe[0]) bank0[wbr[0]] <= wbd[0];
		if (wbe[1]) bank1[wbr[1]] <= wbd[1];
		if (wbe[2]) bank2[wbr[2]] <= wbd[2];
		if (wbe[3]) bank3[wbr[3]] <= wbd[3];
		if (re) begin
			q0 <= bank0[rb[0]];
			q1 <= bank1[rb[1]];
			q2 <= bank2[rb[2]];
			q3 <= bank3[rb[3]];
			rsel0_q <= rl;
		end
	end

	always_comb begin
		qs[0] = q0; qs[1] = q1; qs[2] = q2; qs[3] = q3;
		for (int k = 0; k < 4; k++) rdata[8*k +: 8] = qs[2'(rsel0_q + 2'(k))];
	end
endmodule

// ----- src/rv32_alu.sv -----
// rv32_alu: combinational execute logic for one instruction from operands.
// Depends on rv32_pkg.
`timescale 1ns / 1ps
module rv32_alu (
	input  rv32_pkg::instr_t  ins,
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	input  logic [31:0]       pc,
	input  logic [31:0]       a0_val,
	input  logic [31:0]       a7_val,
	input  logic [31:0]       mem_word,
	output rv32_pkg::result_t res
);
	logic [31:0] imm, addr, val, nxt;
	logic [4:0]  sh;
	logic        wr, jmp, taken, slt, sltu;
	logic [1:0]  svc;

	always_comb begin
		imm = ins.imm_value;
		addr = a + imm;
		sh = imm[4:0];
		slt = $signed(a) < $signed(b);
		sltu = a < b;
		val = 32'd0;
		wr = 1'b0;
		jmp = 1'b0;
		taken = 1'b0;
		nxt = pc + 32'd4;
		svc = rv32_pkg::SVC_NONE;
		case (ins.action)
			rv32_pkg::ACT_ADD:   begin val = a + b; wr = 1'b1; end
			rv32_pkg::ACT_SUB:   begin val = a - b; wr = 1'b1; end
			rv32_pkg::ACT_AND:   begin val = a & b; wr = 1'b1; end
			rv32_pkg::ACT_OR:    begin val = a | b; wr = 1'b1; end
			rv32_pkg::ACT_XOR:   begin val = a ^ b; wr = 1'b1; end
			rv32_pkg::ACT_SLT:   begin val = {31'd0, slt}; wr = 1'b1; end
			rv32_pkg::ACT_SLTU:  begin val = {31'd0, sltu}; wr = 1'b1; end
			rv32_pkg::ACT_ADDI:  begin val = addr; wr = 1'b1; end
			rv32_pkg::ACT_ANDI:  begin val = a & imm; wr = 1'b1; end
			rv32_pkg::ACT_ORI:   begin val = a | imm; wr = 1'b1; end
			rv32_pkg::ACT_SLLI:  begin val = a << sh; wr = 1'b1; end
			rv32_pkg::ACT_SRLI:  begin val = a >> sh; wr = 1'b1; end
			rv32_pkg::ACT_SRAI:  begin val = 32'($signed(a) >>> sh); wr = 1'b1; end
			rv32_pkg::ACT_LUI:   begin val = imm << 12; wr = 1'b1; end
			rv32_pkg::ACT_AUIPC: begin val = pc + (imm << 12); wr = 1'b1; end
			rv32_pkg::ACT_BEQ:   taken = (a == b);
			rv32_pkg::ACT_BNE:   taken = (a != b);
			rv32_pkg::ACT_BLT:   taken = slt;
			rv32_pkg::ACT_BGE:   taken = !slt;
			rv32_pkg::ACT_BLTU:  taken = sltu;
			rv32_pkg::ACT_BGEU:  taken = !sltu;
			rv32_pkg::ACT_JAL: begin
				val = pc + 32'd4; wr = 1'b1; jmp = 1'b1; nxt = pc + imm;
			end
			rv32_pkg::ACT_JALR: begin
				val = pc + 32'd4; wr = 1'b1; jmp = 1'b1; nxt = {addr[31:1], 1'b0};
			end
			rv32_pkg::ACT_LB:  begin val = {{24{mem_word[7]}}, mem_word[7:0]}; wr = 1'b1; end
			rv32_pkg::ACT_LBU: begin val = {24'd0, mem_word[7:0]}; wr = 1'b1; end
			rv32_pkg::ACT_LW:  begin val = mem_word; wr = 1'b1; end
			rv32_pkg::ACT_ECALL: begin
				if (a7_val == rv32_pkg::SVC_CODE_INT) svc = rv32_pkg::SVC_INT;
				else if (a7_val == rv32_pkg::SVC_CODE_STR) svc = rv32_pkg::SVC_STR;
				else if (a7_val == rv32_pkg::SVC_CODE_EXIT) svc = rv32_pkg::SVC_EXIT;
			end
			default: ;
		endcase
		if (taken) begin
			jmp = 1'b1;
			nxt = pc + imm;
		end
		if (!wr || ins.dest_reg == 5'd0) begin
			wr = 1'b0;
			val = 32'd0;
		end
		res.write_enable = wr;
		res.write_value = val;
		res.jumped = jmp;
		res.next_pc = nxt;
		res.service = svc;
		res.service_arg = (ins.action == rv32_pkg::ACT_ECALL) ? a0_val : 32'd0;
	end
endmodule

// ----- src/rv32i_execute_unit.sv -----
// rv32i_execute_unit: top level; register file, data memory, execute logic
// and output register. Depends on rv32_pkg, rv32_regfile, rv32_dmem, rv32_alu.
`timescale 1ns / 1ps
// One instruction is accepted per cycle with no bubbles; only a held output
// stalls the input. At acceptance the register file is read (write-through
// from the write-back of that cycle). Stage 1 executes with operands forwarded
// from the result held in stage 2, and issues the data memory read or write.
// Stage 2 holds the result, completes load data from memory and writes the
// register file in the cycle it is entered. DATA_BYTES must be a power of two;
// addresses wrap on their low bits. Memory needs no clearing after reset.
module rv32i_execute_unit #(
	parameter int DATA_BYTES = rv32_pkg::DATA_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// action[4:0], dest_reg[9:5], src1_reg[14:10], src2_reg[19:15], imm_value[51:20]
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// write_enable[0], write_value[32:1], jumped[33], next_pc[65:34],
	// service[67:66], service_arg[99:68]
	output logic [103:0] m_tdata
);
	logic              v_s1;
	logic              v_s2;
	logic              wb_pend_s2;
	rv32_pkg::instr_t  ins_s1;
	logic [4:0]        rs1_s1;
	logic [4:0]        rs2_s1;
	logic [31:0]       pc_q;
	rv32_pkg::result_t out_s2;
	logic [4:0]        rd_s2;
	logic [4:0]        act_s2;
	logic              ld_s2;
	logic [31:0]       rf_a, rf_b, rf_a0, rf_a7;
	logic [31:0]       a, b, a0v, a7v, mword, maddr;
	rv32_pkg::result_t res;
	rv32_pkg::result_t fin_s2;
	rv32_pkg::rf_wr_t  wb;
	rv32_pkg::instr_t  ins_in;
	logic              adv, take, fwd, is_ld, is_st;

	assign adv = v_s1 && (!v_s2 || m_tready);
	assign s_tready = !v_s1 || adv;
	assign take = s_tvalid && s_tready;

	assign ins_in.action = s_tdata[4:0];
	assign ins_in.dest_reg = s_tdata[9:5];
	assign ins_in.imm_value = s_tdata[51:20];

	rv32_regfile u_rf (
		.clk(clk), .arst_n(arst_n), .rd_en(take),
		.ra1(s_tdata[14:10]), .ra2(s_tdata[19:15]),
		.rd1(rf_a), .rd2(rf_b), .a0_val(rf_a0), .a7_val(rf_a7), .wr(wb)
	);

	// stage 2 result forwarded to stage 1 operands
	assign fwd = v_s2 && fin_s2.write_enable;
	assign a = (fwd && rd_s2 == rs1_s1) ? fin_s2.write_value : rf_a;
	assign b = (fwd && rd_s2 == rs2_s1) ? fin_s2.write_value : rf_b;
	assign a0v = (fwd && rd_s2 == rv32_pkg::REG_A0) ? fin_s2.write_value : rf_a0;
	assign a7v = (fwd && rd_s2 == rv32_pkg::REG_A7) ? fin_s2.write_value : rf_a7;

	assign maddr = a + ins_s1.imm_value;
	assign is_ld = (ins_s1.action == rv32_pkg::ACT_LB) || (ins_s1.action == rv32_pkg::ACT_LBU)
		|| (ins_s1.action == rv32_pkg::ACT_LW);
	assign is_st = (ins_s1.action == rv32_pkg::ACT_SB) || (ins_s1.action == rv32_pkg::ACT_SW);

	rv32_dmem #(.DATA_BYTES(DATA_BYTES)) u_mem (
		.clk(clk), .re(adv && is_ld), .raddr(maddr), .rdata(mword),
		.we(adv && is_st), .waddr(maddr),
		.wbytes((ins_s1.action == rv32_pkg::ACT_SW) ? 4'hF : 4'h1),
		.wdata(b)
	);

	rv32_alu u_alu (
		.ins(ins_s1), .a(a), .b(b), .pc(pc_q), .a0_val(a0v), .a7_val(a7v),
		.mem_word(32'd0), .res(res)
	);

	always_comb begin
		fin_s2 = out_s2;
		if (ld_s2 && out_s2.write_enable) begin
			case (act_s2)
				rv32_pkg::ACT_LB:  fin_s2.write_value = {{24{mword[7]}}, mword[7:0]};
				rv32_pkg::ACT_LBU: fin_s2.write_value = {24'd0, mword[7:0]};
				default:           fin_s2.write_value = mword;
			endcase
		end
	end

	assign wb.en = wb_pend_s2 && fin_s2.write_enable;
	assign wb.addr = rd_s2;
	assign wb.data = fin_s2.write_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			wb_pend_s2 <= 1'b0;
			pc_q <= 32'd0;
		end else begin
			if (take) v_s1 <= 1'b1;
			else if (adv) v_s1 <= 1'b0;
			if (adv) v_s2 <= 1'b1;
			else if (m_tready) v_s2 <= 1'b0;
			wb_pend_s2 <= adv;
			if (adv) pc_q <= res.next_pc;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ins_s1 <= ins_in;
			rs1_s1 <= s_tdata[14:10];
			rs2_s1 <= s_tdata[19:15];
		end
		if (adv) begin
			out_s2 <= res;
			rd_s2 <= ins_s1.dest_reg;
			act_s2 <= ins_s1.action;
			ld_s2 <= is_ld;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata = {4'd0, fin_s2.service_arg, fin_s2.service, fin_s2.next_pc,
		fin_s2.jumped, fin_s2.write_value, fin_s2.write_enable};

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n) adv |=> m_tvalid)
		else $error("no result after advance");
	assert property (@(posedge clk) disable iff (!arst_n) !v_s1 |-> s_tready)
		else $error("stalled while empty");
	assert property (@(posedge clk) disable iff (!arst_n) wb.en |-> v_s2)
		else $error("write-back without result");
endmodule
